// ===== rtl/ski_pkg.sv =====
// ski_pkg: shared types, codes and helpers for the sorted key index.
// Used by ski_cell, ski_tree and sorted_key_index; depends on nothing.

package ski_pkg;

    localparam int KEY_WORDS = 8;
    localparam int WORD_W    = 32;
    localparam int KEY_W     = KEY_WORDS * WORD_W;
    localparam int ENTRY_W   = 8;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int KCOUNT_W  = 9;
    localparam int FAN_IN    = 8;
    localparam int FAN_BITS  = 3;

    // request codes; the unused code behaves as a find
    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // key word 0 sits in the top bits, so a plain unsigned compare orders keys
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [ENTRY_W-1:0] t_entry;

    typedef struct packed {
        t_key   key;
        t_entry entry;
    } t_slot;

    // match flag plus the matching entry (zero when no match)
    typedef struct packed {
        logic   found;
        t_entry entry;
    } t_hit;

    // per-cycle shift command broadcast to the cell row
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cmd;

    // registered levels of the radix-8 match tree
    function automatic int tree_levels(input int n);
        int lv;
        lv = ($clog2(n) + FAN_BITS - 1) / FAN_BITS;
        return (lv < 1) ? 1 : lv;
    endfunction

endpackage

// ===== rtl/sorted_key_index.sv =====
// sorted_key_index: top level of the sorted 256-bit key dictionary.
// Instantiates a row of ski_cell slots and the ski_tree match gatherer.
//
// Usage
//   Request channel (i_in_valid / o_in_ready): op, eight key words (word 0
//   most significant) and an entry number. Op find returns the entry tied
//   to the key; insert places a new key in order; remove deletes it.
//   Result channel (o_out_valid / i_out_ready): status, entry_out and the
//   key count after the request. One result per request, in order.
// Timing
//   Every slot compares its key with the request at the transfer edge.
//   The match flags then climb a registered radix-8 OR tree of
//   L = ceil(log8(CAPACITY)) levels (3 at 256 slots). An apply step then
//   shifts the row and loads the result register, which shows the result.
//   The block takes no new request until that apply step is done, so
//   requests are handled one at a time.
// Reset and stall
//   Synchronous active-low reset empties the table (count to zero), clears
//   the result valid and returns to idle with the request side ready; slot
//   contents are not cleared. The next request is
//   taken while a result waits in the output register; if that register is
//   still full when the following result is due, the shift is held off
//   until the receiver takes the waiting result.

module sorted_key_index #(
    parameter int CAPACITY = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ski_pkg::OP_W-1:0]        i_op,
    input  logic [ski_pkg::WORD_W-1:0]      i_key_0,
    input  logic [ski_pkg::WORD_W-1:0]      i_key_1,
    input  logic [ski_pkg::WORD_W-1:0]      i_key_2,
    input  logic [ski_pkg::WORD_W-1:0]      i_key_3,
    input  logic [ski_pkg::WORD_W-1:0]      i_key_4,
    input  logic [ski_pkg::WORD_W-1:0]      i_key_5,
    input  logic [ski_pkg::WORD_W-1:0]      i_key_6,
    input  logic [ski_pkg::WORD_W-1:0]      i_key_7,
    input  logic [ski_pkg::ENTRY_W-1:0]     i_entry_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ski_pkg::STATUS_W-1:0]    o_status,
    output logic [ski_pkg::ENTRY_W-1:0]     o_entry_out,
    output logic [ski_pkg::KCOUNT_W-1:0]    o_key_count
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int LEVELS = ski_pkg::tree_levels(CAPACITY);
    localparam int LW     = $clog2(LEVELS + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,   // ready for a request
        S_TREE  = 3'b010,   // match flags climbing the tree
        S_APPLY = 3'b100    // shift the row, load the result
    } t_state;

    t_state r_state, n_state;
    logic [LW-1:0] r_lvl, n_lvl;
    logic [CW-1:0] r_count, n_count;

    // held request
    logic [ski_pkg::OP_W-1:0] r_op;
    ski_pkg::t_key            r_key;
    ski_pkg::t_entry          r_entry;

    // result register
    logic                         r_out_valid, n_out_valid;
    logic [ski_pkg::STATUS_W-1:0] r_status, n_status;
    ski_pkg::t_entry              r_entry_out, n_entry_out;
    logic [CW-1:0]                r_kcount, n_kcount;

    ski_pkg::t_key  w_probe;
    logic           w_in_xfer;
    logic           w_go;
    logic           w_full;
    ski_pkg::t_cmd  w_cmd;
    ski_pkg::t_hit  w_match;
    logic [CW+ski_pkg::KCOUNT_W-1:0] w_kcount_ext;

    ski_pkg::t_slot w_slot [CAPACITY];
    logic           w_lt   [CAPACITY];
    ski_pkg::t_hit  w_hit  [CAPACITY];

    assign w_probe   = {i_key_0, i_key_1, i_key_2, i_key_3,
                        i_key_4, i_key_5, i_key_6, i_key_7};
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(CAPACITY));
    // apply only when the result register is free or being emptied
    assign w_go       = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_cmd.ins = w_go && (r_op == ski_pkg::OP_INSERT) && !w_match.found && !w_full;
        w_cmd.rem = w_go && (r_op == ski_pkg::OP_REMOVE) && w_match.found;
    end

    // slot row
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            ski_pkg::t_slot w_left, w_right;
            logic           w_left_lt;
            if (gi == 0) begin : g_first
                assign w_left    = '0;
                assign w_left_lt = 1'b1;
            end else begin : g_mid_l
                assign w_left    = w_slot[gi-1];
                assign w_left_lt = w_lt[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = w_slot[gi];
            end else begin : g_mid_r
                assign w_right = w_slot[gi+1];
            end

            ski_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .i_clk         (i_clk),
                .i_cmp_en      (w_in_xfer),
                .i_probe       (w_probe),
                .i_store_key   (r_key),
                .i_store_entry (r_entry),
                .i_count       (r_count),
                .i_cmd         (w_cmd),
                .i_left        (w_left),
                .i_left_lt     (w_left_lt),
                .i_right       (w_right),
                .o_slot        (w_slot[gi]),
                .o_lt          (w_lt[gi]),
                .o_hit         (w_hit[gi])
            );
        end
    endgenerate

    ski_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk (i_clk),
        .i_hit (w_hit),
        .o_hit (w_match)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        unique case (r_state)
            S_IDLE: begin
                n_lvl = '0;
                if (w_in_xfer) begin
                    n_state = S_TREE;
                end
            end
            S_TREE: begin
                if (r_lvl == LW'(LEVELS - 1)) begin
                    n_state = S_APPLY;
                end else begin
                    n_lvl = r_lvl + 1'b1;
                end
            end
            S_APPLY: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result and count
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_entry_out = r_entry_out;
        n_kcount    = r_kcount;
        if (w_go) begin
            n_out_valid = 1'b1;
            n_entry_out = '0;
            case (r_op)
                ski_pkg::OP_INSERT: begin
                    if (w_match.found) begin
                        n_status = ski_pkg::ST_DUPLICATE;
                    end else if (w_full) begin
                        n_status = ski_pkg::ST_FULL;
                    end else begin
                        n_status = ski_pkg::ST_OK;
                        n_count  = r_count + 1'b1;
                    end
                end
                ski_pkg::OP_REMOVE: begin
                    if (w_match.found) begin
                        n_status = ski_pkg::ST_OK;
                        n_count  = r_count - 1'b1;
                    end else begin
                        n_status = ski_pkg::ST_NOT_FOUND;
                    end
                end
                default: begin
                    // find, and the unused code
                    n_status    = w_match.found ? ski_pkg::ST_OK : ski_pkg::ST_NOT_FOUND;
                    n_entry_out = w_match.entry;
                end
            endcase
            n_kcount = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op    <= i_op;
            r_key   <= w_probe;
            r_entry <= i_entry_in;
        end
        r_status    <= n_status;
        r_entry_out <= n_entry_out;
        r_kcount    <= n_kcount;
    end

    assign w_kcount_ext = {{ski_pkg::KCOUNT_W{1'b0}}, r_kcount};
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_entry_out  = r_entry_out;
    assign o_key_count  = w_kcount_ext[ski_pkg::KCOUNT_W-1:0];

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("key count above capacity");

    a_xfer_to_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_TREE))
        else $error("request transfer did not start the match tree");

    a_result_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == S_APPLY))
        else $error("result appeared outside the apply step");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not raise the key count");

    a_one_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.ins && w_cmd.rem))
        else $error("insert and remove shift in the same cycle");

endmodule

// ===== rtl/ski_cell.sv =====
// ski_cell: one slot of the sorted key row, with its compare flags.
// Shifts toward either neighbor on insert or remove. Uses ski_pkg.

module ski_cell #(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  logic              i_clk,
    input  logic              i_cmp_en,
    input  ski_pkg::t_key     i_probe,
    input  ski_pkg::t_key     i_store_key,
    input  ski_pkg::t_entry   i_store_entry,
    input  logic [CW-1:0]     i_count,
    input  ski_pkg::t_cmd     i_cmd,
    input  ski_pkg::t_slot    i_left,
    input  logic              i_left_lt,
    input  ski_pkg::t_slot    i_right,
    output ski_pkg::t_slot    o_slot,
    output logic              o_lt,
    output ski_pkg::t_hit     o_hit
);

    ski_pkg::t_slot r_slot, n_slot;
    logic           r_lt, n_lt;
    logic           r_eq, n_eq;
    logic           w_occupied;

    // slots below the count hold keys
    assign w_occupied = (i_count > CW'(IDX));

    always_comb begin
        n_lt = w_occupied && (r_slot.key < i_probe);
        n_eq = w_occupied && (r_slot.key == i_probe);
    end

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.ins && !r_lt) begin
            // first slot not below the new key takes it, the rest move up
            if (i_left_lt) begin
                n_slot.key   = i_store_key;
                n_slot.entry = i_store_entry;
            end else begin
                n_slot = i_left;
            end
        end else if (i_cmd.rem && !r_lt) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (i_cmp_en) begin
            r_lt <= n_lt;
            r_eq <= n_eq;
        end
    end

    assign o_slot      = r_slot;
    assign o_lt        = r_lt;
    assign o_hit.found = r_eq;
    assign o_hit.entry = r_eq ? r_slot.entry : '0;

endmodule

// ===== rtl/ski_tree.sv =====
// ski_tree: registered radix-8 OR tree that gathers the cell matches.
// One register level per stage; uses ski_pkg.

module ski_tree #(
    parameter int N = 256
) (
    input  logic            i_clk,
    input  ski_pkg::t_hit   i_hit [N],
    output ski_pkg::t_hit   o_hit
);

    localparam int LEVELS = ski_pkg::tree_levels(N);
    localparam int PAD    = 1 << (ski_pkg::FAN_BITS * LEVELS);
    localparam int FAN    = ski_pkg::FAN_IN;

    ski_pkg::t_hit w_leaf [PAD];
    ski_pkg::t_hit r_node [LEVELS][PAD/FAN];

    genvar gi, glv, gn, gk;

    generate
        for (gi = 0; gi < PAD; gi++) begin : g_leaf
            if (gi < N) begin : g_used
                assign w_leaf[gi] = i_hit[gi];
            end else begin : g_pad
                assign w_leaf[gi] = '0;
            end
        end

        for (glv = 0; glv < LEVELS; glv++) begin : g_lvl
            localparam int NODES = PAD >> (ski_pkg::FAN_BITS * (glv + 1));
            for (gn = 0; gn < NODES; gn++) begin : g_node
                ski_pkg::t_hit w_child [FAN];
                ski_pkg::t_hit n_node;
                for (gk = 0; gk < FAN; gk++) begin : g_ch
                    if (glv == 0) begin : g_from_leaf
                        assign w_child[gk] = w_leaf[gn*FAN + gk];
                    end else begin : g_from_node
                        assign w_child[gk] = r_node[glv-1][gn*FAN + gk];
                    end
                end
                always_comb begin
                    n_node = '0;
                    for (int k = 0; k < FAN; k++) begin
                        n_node = n_node | w_child[k];
                    end
                end
                always_ff @(posedge i_clk) begin
                    r_node[glv][gn] <= n_node;
                end
            end
        end
    endgenerate

    assign o_hit = r_node[LEVELS-1][0];

endmodule
